// ----- rtl/md4_pkg.sv -----
`default_nettype none
package md4_pkg;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] ROUND2_K = 32'h5A827999;
  localparam logic [31:0] ROUND3_K = 32'h6ED9EBA1;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LAST_STEP = 6'd47;
  localparam logic [3:0]  LEN_LO_WORD = 4'd14;
  localparam logic [3:0]  LEN_HI_WORD = 4'd15;
  localparam logic [4:0]  ZERO_LIMIT = 5'd14;
  localparam logic [4:0]  WORD_COUNT = 5'd16;

  typedef struct packed {
    logic       load;
    logic       run;
    logic [5:0] step;
  } md4_ctrl_t;

  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [3:0] idx;
    unique case (step[5:4])
      2'd0:    idx = step[3:0];
      2'd1:    idx = {step[1:0], step[3:2]};
      default: idx = {step[0], step[1], step[2], step[3]};
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] step);
    logic [4:0] s;
    unique case (step[5:4])
      2'd0: begin
        unique case (step[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd7;
          2'd2:    s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      2'd1: begin
        unique case (step[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd5;
          2'd2:    s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        unique case (step[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd9;
          2'd2:    s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/md4_msg_mem.sv -----
`default_nettype none
module md4_msg_mem
  import md4_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        we,
  input  wire logic [3:0]  waddr,
  input  wire logic [31:0] wdata,
  input  wire logic [3:0]  raddr,
  output logic      [31:0] rdata
);

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/md4_round.sv -----
`default_nettype none
module md4_round
  import md4_pkg::*;
(
  input  wire logic                  clk,
  input  wire md4_ctrl_t             ctrl,
  input  wire logic [3:0][31:0]      chain,
  input  wire logic [31:0]           x_word,
  output logic      [3:0][31:0]      work
);

  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] f_val, k_val, sum;
  logic [63:0] rot;
  logic [4:0]  s;

  always_comb begin
    s = rot_amount(ctrl.step);
    unique case (ctrl.step[5:4])
      2'd0: begin
        f_val = (b_r & c_r) | (~b_r & d_r);
        k_val = 32'd0;
      end
      2'd1: begin
        f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        k_val = ROUND2_K;
      end
      default: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = ROUND3_K;
      end
    endcase
    sum = a_r + f_val + x_word + k_val;
    rot = {sum, sum} << s;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_r <= chain[0];
      b_r <= chain[1];
      c_r <= chain[2];
      d_r <= chain[3];
    end else if (ctrl.run) begin
      a_r <= d_r;
      b_r <= rot[63:32];
      c_r <= b_r;
      d_r <= c_r;
    end
  end

  assign work = {d_r, c_r, b_r, a_r};

endmodule
`default_nettype wire

// ----- rtl/md4_message_digest.sv -----
// One byte transaction per cycle while filling a 64-byte block, as long as the
// block is idle with in_ready high. A full block then takes one preload,
// 48 steps (one memory read per step through the single block memory read
// port) and one chaining add. The end transaction adds 3 to 18 word writes
// for padding and length, one or two compressions and then the digest.
// Synchronous active-low reset restores the initial chaining words and count.
`default_nettype none
module md4_message_digest
  import md4_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_message_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [63:0] out_digest_low,
  output logic      [63:0] out_digest_high
);

  typedef enum logic [3:0] {
    S_IDLE, S_PAD, S_ZERO, S_LEN_LO, S_LEN_HI, S_PREP, S_COMP, S_FIN, S_OUT
  } state_t;

  state_t            state_r;
  logic [63:0]       cnt_r;
  logic [23:0]       acc_r;
  logic [3:0][31:0]  chain_r;
  logic [5:0]        step_r;
  logic [4:0]        zidx_r;
  logic              wrap_r, end_r, padded_r, len_r;

  logic              in_fire;
  logic [5:0]        pos;
  logic [31:0]       pad_word;
  logic [4:0]        zlimit;
  logic              we;
  logic [3:0]        waddr, raddr;
  logic [31:0]       wdata, rdata;
  logic [3:0][31:0]  work;
  md4_ctrl_t         ctrl;

  assign pos     = cnt_r[5:0];
  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid && in_ready;
  assign zlimit  = wrap_r ? WORD_COUNT : ZERO_LIMIT;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (k < 3 && 2'(k) < pos[1:0]) begin
        pad_word[k*8 +: 8] = acc_r[(k % 3)*8 +: 8];
      end else if (2'(k) == pos[1:0]) begin
        pad_word[k*8 +: 8] = PAD_BYTE;
      end else begin
        pad_word[k*8 +: 8] = 8'd0;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos[5:2];
    wdata = 32'd0;
    raddr = msg_index(6'(step_r + 6'd1));
    unique case (state_r)
      S_IDLE: begin
        we    = in_fire && in_byte_present && (pos[1:0] == 2'd3);
        wdata = {in_message_byte, acc_r};
      end
      S_PAD: begin
        we    = 1'b1;
        wdata = pad_word;
      end
      S_ZERO: begin
        we    = (zidx_r != zlimit);
        waddr = zidx_r[3:0];
      end
      S_LEN_LO: begin
        we    = 1'b1;
        waddr = LEN_LO_WORD;
        wdata = {cnt_r[28:0], 3'b000};
      end
      S_LEN_HI: begin
        we    = 1'b1;
        waddr = LEN_HI_WORD;
        wdata = cnt_r[60:29];
      end
      S_PREP: raddr = msg_index(6'd0);
      default: ;
    endcase
  end

  assign ctrl = {(state_r == S_PREP), (state_r == S_COMP), step_r};

  md4_msg_mem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  md4_round u_round (
    .clk    (clk),
    .ctrl   (ctrl),
    .chain  (chain_r),
    .x_word (rdata),
    .work   (work)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= 64'd0;
      chain_r  <= {H3_INIT, H2_INIT, H1_INIT, H0_INIT};
      step_r   <= 6'd0;
      zidx_r   <= 5'd0;
      wrap_r   <= 1'b0;
      end_r    <= 1'b0;
      padded_r <= 1'b0;
      len_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_byte_present) begin
              cnt_r <= cnt_r + 64'd1;
              unique case (pos[1:0])
                2'd0:    acc_r[7:0]   <= in_message_byte;
                2'd1:    acc_r[15:8]  <= in_message_byte;
                2'd2:    acc_r[23:16] <= in_message_byte;
                default: ;
              endcase
              if (pos == 6'd63) begin
                end_r   <= in_end_of_message;
                state_r <= S_PREP;
              end else if (in_end_of_message) begin
                end_r   <= 1'b1;
                state_r <= S_PAD;
              end
            end else if (in_end_of_message) begin
              end_r   <= 1'b1;
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          padded_r <= 1'b1;
          zidx_r   <= {1'b0, pos[5:2]} + 5'd1;
          wrap_r   <= (pos[5:2] >= LEN_LO_WORD);
          state_r  <= S_ZERO;
        end
        S_ZERO: begin
          if (zidx_r == zlimit) begin
            if (wrap_r) begin
              wrap_r  <= 1'b0;
              state_r <= S_PREP;
            end else begin
              state_r <= S_LEN_LO;
            end
          end else begin
            zidx_r <= zidx_r + 5'd1;
          end
        end
        S_LEN_LO: state_r <= S_LEN_HI;
        S_LEN_HI: begin
          len_r   <= 1'b1;
          state_r <= S_PREP;
        end
        S_PREP: begin
          step_r  <= 6'd0;
          state_r <= S_COMP;
        end
        S_COMP: begin
          step_r <= step_r + 6'd1;
          if (step_r == LAST_STEP) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          for (int i = 0; i < 4; i++) begin
            chain_r[i] <= chain_r[i] + work[i];
          end
          priority if (!end_r) begin
            state_r <= S_IDLE;
          end else if (!padded_r) begin
            state_r <= S_PAD;
          end else if (!len_r) begin
            zidx_r  <= 5'd0;
            wrap_r  <= 1'b0;
            state_r <= S_ZERO;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state_r  <= S_IDLE;
            cnt_r    <= 64'd0;
            chain_r  <= {H3_INIT, H2_INIT, H1_INIT, H0_INIT};
            end_r    <= 1'b0;
            padded_r <= 1'b0;
            len_r    <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = (state_r == S_OUT);
  assign out_digest_low  = {chain_r[1], chain_r[0]};
  assign out_digest_high = {chain_r[3], chain_r[2]};

endmodule
`default_nettype wire

// ----- rtl/md4_checker.sv -----
`default_nettype none
module md4_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_digest_low,
  input wire logic [63:0] out_digest_high
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_low)
      && $stable(out_digest_high))
    else $error("digest changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while digest pending");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_ret_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("no return to idle after digest transaction");

endmodule

bind md4_message_digest md4_checker u_md4_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digest_low  (out_digest_low),
  .out_digest_high (out_digest_high)
);
`default_nettype wire

// ----- bench/md4_message_digest_tb.sv -----
`timescale 1ns / 100ps
module md4_message_digest_tb;
  import md4_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_OFF_AT = 4;
  localparam int HOLD_OFF_CYCLES = 3000;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } msg_item_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_message_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_digest_low;
  logic [63:0] out_digest_high;

  md4_message_digest dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_message_byte   (in_message_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_low    (out_digest_low),
    .out_digest_high   (out_digest_high)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- digest predictor ----------------
  logic [31:0] chain_w [4];
  logic [31:0] blk_w [16];
  logic [63:0] msg_len_bytes;
  digest_t     expected_digests [$];

  function automatic logic [31:0] rol32(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic int rot_for(int rnd, int lane);
    case (rnd)
      0:       return (lane == 0) ? 3 : (lane == 1) ? 7 : (lane == 2) ? 11 : 19;
      1:       return (lane == 0) ? 3 : (lane == 1) ? 5 : (lane == 2) ? 9 : 13;
      default: return (lane == 0) ? 3 : (lane == 1) ? 9 : (lane == 2) ? 11 : 15;
    endcase
  endfunction

  task automatic md4_restart();
    chain_w[0] = H0_INIT;
    chain_w[1] = H1_INIT;
    chain_w[2] = H2_INIT;
    chain_w[3] = H3_INIT;
    for (int n = 0; n < 16; n++) blk_w[n] = 32'h0;
    msg_len_bytes = 64'h0;
  endtask

  task automatic md4_compress();
    logic [31:0] w [4];
    logic [31:0] x, y, z, f, k;
    int s, i, rnd, t, idx;
    for (int n = 0; n < 4; n++) w[n] = chain_w[n];
    for (s = 0; s < 48; s++) begin
      i = s % 16;
      rnd = s / 16;
      // each step rotates through the words: a, d, c, b
      t = (4 - (i % 4)) % 4;
      x = w[(t + 1) % 4];
      y = w[(t + 2) % 4];
      z = w[(t + 3) % 4];
      case (rnd)
        0: begin
          f = (x & y) | (~x & z);
          idx = i;
          k = 32'h0;
        end
        1: begin
          f = (x & y) | (x & z) | (y & z);
          idx = (i % 4) * 4 + i / 4;
          k = ROUND2_K;
        end
        default: begin
          f = x ^ y ^ z;
          idx = {28'd0, i[0], i[1], i[2], i[3]};
          k = ROUND3_K;
        end
      endcase
      w[t] = rol32(w[t] + f + blk_w[idx] + k, rot_for(rnd, i % 4));
    end
    for (int n = 0; n < 4; n++) chain_w[n] = chain_w[n] + w[n];
  endtask

  task automatic put_byte(int pos, logic [7:0] b);
    blk_w[pos / 4][(pos % 4) * 8 +: 8] = b;
  endtask

  task automatic md4_absorb(msg_item_t it);
    int pos;
    logic [63:0] bits;
    if (it.present) begin
      pos = int'(msg_len_bytes[5:0]);
      put_byte(pos, it.data);
      msg_len_bytes = msg_len_bytes + 64'd1;
      if (pos == 63) md4_compress();
    end
    if (it.last) begin
      pos = int'(msg_len_bytes[5:0]);
      put_byte(pos, PAD_BYTE);
      pos++;
      if (pos > 56) begin
        for (int j = pos; j < 64; j++) put_byte(j, 8'h00);
        md4_compress();
        pos = 0;
      end
      for (int j = pos; j < 56; j++) put_byte(j, 8'h00);
      bits = msg_len_bytes << 3;
      blk_w[LEN_LO_WORD] = bits[31:0];
      blk_w[LEN_HI_WORD] = bits[63:32];
      md4_compress();
      expected_digests.push_back('{lo: {chain_w[1], chain_w[0]},
                                   hi: {chain_w[3], chain_w[2]}});
      md4_restart();
    end
  endtask

  // ---------------- stimulus ----------------
  msg_item_t item_q [$];
  int        items_total = 0;
  int        items_accepted = 0;
  int        failures = 0;

  task automatic push_item(logic [7:0] data, logic present, logic last);
    item_q.push_back('{data: data, present: present, last: last});
    items_total++;
  endtask

  task automatic queue_message(int len, bit split_end);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 19) == 0) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(8'($urandom), 1'b1, (!split_end && n == len - 1));
    end
    if (split_end || len == 0) push_item(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int pick_length();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(0, 64);
    if (sel < 9) begin
      case ($urandom_range(0, 5))
        0:       return 64 * $urandom_range(0, 1) + 55;
        1:       return 64 * $urandom_range(0, 1) + 56;
        2:       return 64 * $urandom_range(0, 1) + 57;
        3:       return 64 * $urandom_range(0, 1) + 63;
        4:       return 64 * $urandom_range(1, 2);
        default: return 64 * $urandom_range(1, 2) + 1;
      endcase
    end
    return $urandom_range(65, 200);
  endfunction

  // ---------------- driver ----------------
  int        burst_left = 0;
  int        gap_left = 0;
  msg_item_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        md4_absorb('{data: in_message_byte, present: in_byte_present,
                     last: in_end_of_message});
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (item_q.size() != 0) begin
          next_item = item_q.pop_front();
          in_valid <= 1'b1;
          in_message_byte <= next_item.data;
          in_byte_present <= next_item.present;
          in_end_of_message <= next_item.last;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            gap_left = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver ----------------
  int          digests_seen = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          pattern_age = 0;
  logic [15:0] ready_pattern = 16'hffff;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && digests_seen == HOLD_OFF_AT) begin
      // long back-pressure so the block holds its digest and stalls its input
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
        pattern_age = 256;
      end
      pattern_age--;
      out_ready <= ready_pattern[pattern_age % 16];
    end
  end

  // ---------------- monitor ----------------
  digest_t exp_digest;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      digests_seen <= digests_seen + 1;
      if (expected_digests.size() == 0) begin
        $error("unexpected digest transaction: low %h high %h",
               out_digest_low, out_digest_high);
        failures++;
      end else begin
        exp_digest = expected_digests.pop_front();
        if (out_digest_low !== exp_digest.lo) begin
          $error("digest_low: expected %h, got %h", exp_digest.lo, out_digest_low);
          failures++;
        end
        if (out_digest_high !== exp_digest.hi) begin
          $error("digest_high: expected %h, got %h", exp_digest.hi, out_digest_high);
          failures++;
        end
      end
    end
  end

  // ---------------- timeout ----------------
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("md4_message_digest_tb NOT OK");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  int counted;

  initial begin
    md4_restart();

    // directed: empty message, ignored items, end with and without a byte
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'hff, 1'b0, 1'b0);
    push_item(8'h61, 1'b1, 1'b1);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hff, 1'b1, 1'b1);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b1);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      int len;
      int before_n;
      len = pick_length();
      before_n = items_total;
      queue_message(len, $urandom_range(0, 1) == 1);
      counted += items_total - before_n;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (items_accepted != items_total) @(posedge clk);
    while (expected_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("md4_message_digest_tb OK");
    end else begin
      $display("md4_message_digest_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- md4_message_digest.f -----
rtl/md4_pkg.sv
rtl/md4_msg_mem.sv
rtl/md4_round.sv
rtl/md4_message_digest.sv
rtl/md4_checker.sv
bench/md4_message_digest_tb.sv
